[rtl/core/spws_pkg.sv]
// ----------------------------------------------------------------------------
// spws_pkg
// Shared types and constants of the spectral peak window selector: the
// register map, the layout of one result, and the status codes.
// ----------------------------------------------------------------------------
package spws_pkg;

  localparam int SAMPLE_BITS_DEF = 32;
  localparam int INDEX_BITS_DEF  = 16;

  // Width of index and count fields on the result side
  localparam int POS_BITS        = 16;
  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int OUT_DATA_BITS   = 72;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_FLOOR_LEVEL    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_PROMINENCE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_RADIUS  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_WINDOWS    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INVALID_CODE   = 3'd4;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW   = 2'd1;
  localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;
  localparam logic [1:0] STATUS_UNUSED     = 2'd3;

  typedef struct packed {
    logic signed [31:0] floor_level;
    logic [30:0]        min_prominence;
    logic [15:0]        window_radius;
    logic [15:0]        max_windows;
    logic [31:0]        invalid_code;
  } cfg_t;

  typedef struct packed {
    logic                present;
    logic [POS_BITS-1:0] win_start;
    logic [POS_BITS-1:0] win_end;
    logic [POS_BITS-1:0] win_peak;
    logic                done;
    logic [1:0]          status;
    logic [POS_BITS-1:0] total;
  } result_t;

  // Results produced by one accepted sample, in delivery order
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

[rtl/core/spws_detect.sv]
// ----------------------------------------------------------------------------
// spws_detect
// Peak test on the middle of the last three samples, window building and
// merging, and end-of-trace flush. One sample is processed per accept.
// ----------------------------------------------------------------------------
module spws_detect #(
  parameter int SAMPLE_BITS = spws_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = spws_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          eot,
  input  spws_pkg::cfg_t                cfg,
  output spws_pkg::push_t               push
);
  import spws_pkg::*;

  localparam int LAST_BITS = POS_BITS + 1;
  localparam int CNT_BITS  = INDEX_BITS + 1;
  localparam logic [CNT_BITS-1:0] MAX_LEN = CNT_BITS'((1 << INDEX_BITS) - 1);
  localparam int THR_BITS  = 34;

  logic signed [SAMPLE_BITS-1:0] older_sample, older_sample_next;
  logic signed [SAMPLE_BITS-1:0] middle_sample, middle_sample_next;
  logic [CNT_BITS-1:0]           sample_index, sample_index_next;
  logic                          open_valid, open_valid_next;
  logic [INDEX_BITS-1:0]         open_first, open_first_next;
  logic [LAST_BITS-1:0]          open_last, open_last_next;
  logic [INDEX_BITS-1:0]         open_peak_index, open_peak_index_next;
  logic signed [SAMPLE_BITS-1:0] open_peak_value, open_peak_value_next;
  logic [POS_BITS-1:0]           windows_sent, windows_sent_next;
  logic                          overflow_flag, overflow_flag_next;

  logic                          in_range;
  logic [INDEX_BITS-1:0]         p;
  logic signed [THR_BITS-1:0]    thr;
  logic signed [THR_BITS-1:0]    v_ext;
  logic                          is_peak;
  logic [LAST_BITS-1:0]          p_w, rad_w, first_w, last_w;
  logic                          merge;
  logic                          full;
  logic                          emit;
  logic                          bad_len;
  logic [LAST_BITS-1:0]          clamp_last;
  result_t                       r_emit, r_final;

  always_comb begin
    in_range = !overflow_flag && (sample_index >= CNT_BITS'(2)) &&
               (sample_index <= MAX_LEN - CNT_BITS'(1));
    p        = sample_index[INDEX_BITS-1:0] - INDEX_BITS'(1);
    thr      = THR_BITS'($signed(cfg.floor_level)) +
               $signed({3'b000, cfg.min_prominence});
    v_ext    = THR_BITS'(middle_sample);
    is_peak  = in_range && (middle_sample != cfg.invalid_code[SAMPLE_BITS-1:0]) &&
               (v_ext >= thr) && (middle_sample >= older_sample) &&
               (middle_sample >= sample);

    p_w     = LAST_BITS'(p);
    rad_w   = LAST_BITS'(cfg.window_radius);
    first_w = (p_w > rad_w) ? p_w - rad_w : '0;
    last_w  = p_w + rad_w;
    merge   = open_valid &&
              ({1'b0, first_w} <= {1'b0, open_last} + (LAST_BITS + 1)'(1));
    full    = ({1'b0, windows_sent} + (POS_BITS + 1)'(open_valid)) >=
              {1'b0, cfg.max_windows};

    older_sample_next    = middle_sample;
    middle_sample_next   = sample;
    sample_index_next    = (sample_index <= MAX_LEN) ? sample_index + CNT_BITS'(1)
                                                     : sample_index;
    open_valid_next      = open_valid;
    open_first_next      = open_first;
    open_last_next       = open_last;
    open_peak_index_next = open_peak_index;
    open_peak_value_next = open_peak_value;
    windows_sent_next    = windows_sent;
    overflow_flag_next   = overflow_flag;
    emit                 = 1'b0;

    r_emit           = '0;
    r_emit.present   = 1'b1;
    r_emit.win_start = POS_BITS'(open_first);
    r_emit.win_end   = open_last[POS_BITS-1:0];
    r_emit.win_peak  = POS_BITS'(open_peak_index);

    if (is_peak) begin
      if (merge) begin
        if (last_w > open_last) begin
          open_last_next = last_w;
        end
        // ties keep the older peak
        if (middle_sample > open_peak_value) begin
          open_peak_index_next = p;
          open_peak_value_next = middle_sample;
        end
      end else if (full) begin
        overflow_flag_next = 1'b1;
      end else begin
        if (open_valid) begin
          emit              = 1'b1;
          windows_sent_next = windows_sent + POS_BITS'(1);
        end
        open_valid_next      = 1'b1;
        open_first_next      = first_w[INDEX_BITS-1:0];
        open_last_next       = last_w;
        open_peak_index_next = p;
        open_peak_value_next = middle_sample;
      end
    end

    bad_len    = (sample_index < CNT_BITS'(2)) || (sample_index >= MAX_LEN);
    clamp_last = (open_last_next > LAST_BITS'(sample_index)) ? LAST_BITS'(sample_index)
                                                              : open_last_next;
    r_final      = '0;
    r_final.done = 1'b1;
    if (bad_len) begin
      r_final.status = STATUS_BAD_LENGTH;
      r_final.total  = windows_sent_next;
    end else begin
      r_final.status = overflow_flag_next ? STATUS_OVERFLOW : STATUS_OK;
      if (open_valid_next) begin
        r_final.present   = 1'b1;
        r_final.win_start = POS_BITS'(open_first_next);
        r_final.win_end   = clamp_last[POS_BITS-1:0];
        r_final.win_peak  = POS_BITS'(open_peak_index_next);
        r_final.total     = windows_sent_next + POS_BITS'(1);
      end else begin
        r_final.total = windows_sent_next;
      end
    end

    push.count = accept ? ({1'b0, emit} + {1'b0, eot}) : 2'd0;
    push.r0    = emit ? r_emit : r_final;
    push.r1    = r_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample    <= '0;
      middle_sample   <= '0;
      sample_index    <= '0;
      open_valid      <= 1'b0;
      open_first      <= '0;
      open_last       <= '0;
      open_peak_index <= '0;
      open_peak_value <= '0;
      windows_sent    <= '0;
      overflow_flag   <= 1'b0;
    end else if (accept) begin
      if (eot) begin
        // start the next trace from a clean slate
        older_sample    <= '0;
        middle_sample   <= '0;
        sample_index    <= '0;
        open_valid      <= 1'b0;
        open_first      <= '0;
        open_last       <= '0;
        open_peak_index <= '0;
        open_peak_value <= '0;
        windows_sent    <= '0;
        overflow_flag   <= 1'b0;
      end else begin
        older_sample    <= older_sample_next;
        middle_sample   <= middle_sample_next;
        sample_index    <= sample_index_next;
        open_valid      <= open_valid_next;
        open_first      <= open_first_next;
        open_last       <= open_last_next;
        open_peak_index <= open_peak_index_next;
        open_peak_value <= open_peak_value_next;
        windows_sent    <= windows_sent_next;
        overflow_flag   <= overflow_flag_next;
      end
    end
  end

endmodule

[rtl/core/spws_queue.sv]
// ----------------------------------------------------------------------------
// spws_queue
// Small result queue: takes up to two results per cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module spws_queue #(
  parameter int DEPTH = spws_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  spws_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output spws_pkg::result_t out_data
);
  import spws_pkg::*;

  localparam int PW = $clog2(DEPTH);

  result_t         mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count, count_next;
  logic            pop;

  assign out_valid  = (count != '0);
  assign out_data   = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign room       = (count <= (PW + 1)'(DEPTH - 2));
  assign count_next = count + (PW + 1)'(push.count) - (PW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PW'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count_next;
    end
  end

endmodule

[rtl/core/spectral_peak_window_select.sv]
// Results of an accepted sample go through the result queue to the master side.
// Throughput: one sample per cycle; a sample that closes one window and ends the
// trace yields two results, drained one per cycle while m_tready is high through a
// four-entry result queue. s_tready drops while under two queue entries are free.
// Reset (rst, synchronous): clears trace state and the queue, loads register defaults.
// ----------------------------------------------------------------------------
// spectral_peak_window_select
// Finds local maxima in a spectrum trace, widens them to windows, merges
// touching windows and streams the finished windows plus a trace status.
// ----------------------------------------------------------------------------
module spectral_peak_window_select #(
  parameter int SAMPLE_BITS = spws_pkg::SAMPLE_BITS_DEF,
  parameter int INDEX_BITS  = spws_pkg::INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // sample_value
  input  logic                                s_tlast,   // end_of_trace
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // window start, window end, peak position, status_code, window_total, zero pad
  output logic [spws_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  output logic                                m_tuser,   // window_present
  output logic                                m_tlast,   // trace_done
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [spws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [spws_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import spws_pkg::*;

  localparam int PAD_BITS = OUT_DATA_BITS - (4 * POS_BITS + 2);

  cfg_t    cfg;
  push_t   push;
  result_t res;
  logic    accept;
  logic    room;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.floor_level    <= '0;
      cfg.min_prominence <= '0;
      cfg.window_radius  <= '0;
      cfg.max_windows    <= 16'd1;
      cfg.invalid_code   <= 32'h8000_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FLOOR_LEVEL:    cfg.floor_level    <= cfg_data;
        CFG_MIN_PROMINENCE: cfg.min_prominence <= cfg_data[30:0];
        CFG_WINDOW_RADIUS:  cfg.window_radius  <= cfg_data[15:0];
        CFG_MAX_WINDOWS:    cfg.max_windows    <= cfg_data[15:0];
        CFG_INVALID_CODE:   cfg.invalid_code   <= cfg_data;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  spws_detect #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_detect (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (s_tdata[SAMPLE_BITS-1:0]),
    .eot    (s_tlast),
    .cfg    (cfg),
    .push   (push)
  );

  spws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {{PAD_BITS{1'b0}}, res.total, res.status, res.win_peak,
                    res.win_end, res.win_start};
  assign m_tuser = res.present;
  assign m_tlast = res.done;

endmodule

[rtl/core/spws_check.sv]
// ----------------------------------------------------------------------------
// spws_check
// Port-level checks on the result stream of the window selector.
// ----------------------------------------------------------------------------
module spws_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [spws_pkg::OUT_DATA_BITS-1:0] m_tdata,
  input logic                               m_tuser,
  input logic                               m_tlast
);
  import spws_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
    $stable(m_tlast))
    else $error("result changed while stalled");

  // results ahead of the trace end only carry closed windows, no status
  a_mid_trace: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser && (m_tdata[49:48] == STATUS_OK) &&
    (m_tdata[65:50] == '0))
    else $error("mid-trace result without window or with status");

  a_no_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[47:0] == '0))
    else $error("window fields set without a window");

  // the flushed window is clamped, so its peak lies inside it
  a_peak_inside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && m_tuser |-> (m_tdata[47:32] >= m_tdata[15:0]) &&
    (m_tdata[47:32] <= m_tdata[31:16]) && (m_tdata[49:48] != STATUS_BAD_LENGTH))
    else $error("final window does not hold its peak");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[49:48] != STATUS_UNUSED))
    else $error("undefined status code");

endmodule

bind spectral_peak_window_select spws_check u_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
